// ----- src/smf_pkg.sv -----
// Shared types and constants for the Sobel and motion fusion filter.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package smf_pkg;

  localparam int PIXEL_BITS     = 8;
  localparam int DEF_MAX_WIDTH  = 2048;
  localparam int DEF_MAX_HEIGHT = 2048;

  localparam int CFG_W       = 12;
  localparam int WEIGHT_W    = 10;
  localparam int REG_IDX_W   = 2;
  localparam int COORD_W     = 11;
  localparam int FUSED_W     = 19;
  localparam int FRAC_BITS   = 13;
  localparam int MOTION_SHL  = 3;

  localparam int GRAD_W  = PIXEL_BITS + 4;
  localparam int SQ_W    = 2 * GRAD_W;
  localparam int DIFF_W  = PIXEL_BITS + 1;
  localparam int DSQ_W   = 2 * DIFF_W;
  localparam int PROD_W  = SQ_W + WEIGHT_W + 2;

  localparam logic [REG_IDX_W-1:0] REG_FRAME_WIDTH   = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_FRAME_HEIGHT  = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_EDGE_WEIGHT   = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_MOTION_WEIGHT = 2'd3;

  localparam logic [CFG_W-1:0]    RST_FRAME_WIDTH   = 12'd1280;
  localparam logic [CFG_W-1:0]    RST_FRAME_HEIGHT  = 12'd720;
  localparam logic [WEIGHT_W-1:0] RST_EDGE_WEIGHT   = 10'd717;
  localparam logic [WEIGHT_W-1:0] RST_MOTION_WEIGHT = 10'd307;

  typedef struct packed {
    logic [PIXEL_BITS-1:0] curr_pixel;
    logic [PIXEL_BITS-1:0] prev_pixel;
    logic                  start_of_frame;
  } pixel_req_t;

  typedef struct packed {
    logic [FUSED_W-1:0] fused_value;
    logic [COORD_W-1:0] center_row;
    logic [COORD_W-1:0] center_col;
    logic               frame_done;
  } fused_req_t;

  // Controller to datapath commands, one step per cycle while no step waits on a handshake.
  typedef struct packed {
    logic load;
    logic upd;
    logic sq;
    logic sum;
    logic mul;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic interior;
  } dp_status_t;

endpackage

// ----- src/sobel_motion_fusion_filter_core.sv -----
// Top level of the Sobel edge and motion fusion filter.
// Depends on smf_pkg, smf_ctrl and smf_datapath.
`timescale 1ns / 1ps

// Usage:
// Feed pixels in raster order on the input request channel (in_valid_i /
// in_ready_o / in_data_i): the current frame pixel, the co-located previous
// frame pixel and a start-of-frame flag that restarts the row and column
// counters. Each interior window center gives one request on the output
// channel (out_valid_o / out_ready_i / out_data_o); border pixels give none.
// Sequencing: the controller walks one pixel at a time through line store
// read, window update, square, sum, weight multiply and final add; a border
// pixel returns to idle after the window update. A new pixel is accepted only
// once the previous one has left these steps. The result is loaded into the
// output register by the final add step, provided the output register is free.
// A full output register is held until taken; the next pixel is accepted
// meanwhile, and only the final add step waits for the output to drain.
// Reset clears counters, window, handshake state and loads the default geometry
// and weights. The line stores need no clearing: an entry is written before any
// result uses it. Write configuration via cfg_we_i only while idle.

module sobel_motion_fusion_filter_core
  import smf_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  pixel_req_t           in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output fused_req_t           out_data_o,
  input  logic                 cfg_we_i,
  input  logic [REG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_data_i
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  // sequence one request at a time through the datapath
  smf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // line stores, window and arithmetic
  smf_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .in_data_i   (in_data_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

endmodule

// ----- src/smf_ctrl.sv -----
// Sequencing state machine of the fusion filter.
// Depends on smf_pkg for the command and status structs.
`timescale 1ns / 1ps

module smf_ctrl
  import smf_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  input  dp_status_t status_i,
  output ctrl_cmd_t  cmd_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_UPD  = 3'd1;
  localparam logic [2:0] S_SQ   = 3'd2;
  localparam logic [2:0] S_SUM  = 3'd3;
  localparam logic [2:0] S_MUL  = 3'd4;
  localparam logic [2:0] S_ACC  = 3'd5;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_UPD;
        end
      end
      S_UPD: begin
        cmd_o.upd = 1'b1;
        state_d   = status_i.interior ? S_SQ : S_IDLE;
      end
      S_SQ: begin
        cmd_o.sq = 1'b1;
        state_d  = S_SUM;
      end
      S_SUM: begin
        cmd_o.sum = 1'b1;
        state_d   = S_MUL;
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = S_ACC;
      end
      S_ACC: begin
        // hold until the output register is free
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;
    if (cmd_o.out_load)             out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ----- src/smf_datapath.sv -----
// Line stores, 3x3 window, raster counters, registers and fusion arithmetic.
// Depends on smf_pkg; driven step by step by smf_ctrl.
`timescale 1ns / 1ps

module smf_datapath
  import smf_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  ctrl_cmd_t            cmd_i,
  output dp_status_t           status_o,
  input  pixel_req_t           in_data_i,
  output fused_req_t           out_data_o,
  input  logic                 cfg_we_i,
  input  logic [REG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_data_i
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);

  // configuration registers
  logic [CFG_W-1:0]    width_q, height_q;
  logic [WEIGHT_W-1:0] edge_w_q, motion_w_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q    <= RST_FRAME_WIDTH;
      height_q   <= RST_FRAME_HEIGHT;
      edge_w_q   <= RST_EDGE_WEIGHT;
      motion_w_q <= RST_MOTION_WEIGHT;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_FRAME_WIDTH:   width_q    <= cfg_data_i;
        REG_FRAME_HEIGHT:  height_q   <= cfg_data_i;
        REG_EDGE_WEIGHT:   edge_w_q   <= cfg_data_i[WEIGHT_W-1:0];
        REG_MOTION_WEIGHT: motion_w_q <= cfg_data_i[WEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  // clamped geometry
  logic [WW-1:0] w_eff;
  logic [HW-1:0] h_eff;

  always_comb begin
    if (32'(width_q) < 32'd3)              w_eff = WW'(3);
    else if (32'(width_q) > MAX_WIDTH)     w_eff = WW'(MAX_WIDTH);
    else                                   w_eff = WW'(width_q);
    if (32'(height_q) < 32'd3)             h_eff = HW'(3);
    else if (32'(height_q) > MAX_HEIGHT)   h_eff = HW'(MAX_HEIGHT);
    else                                   h_eff = HW'(height_q);
  end

  // raster counters and window state
  logic [CW-1:0]         col_q;
  logic [RW-1:0]         row_q;
  logic [PIXEL_BITS-1:0] hold_q;
  logic [PIXEL_BITS-1:0] win_q [6];
  logic [CW-1:0]         rd_addr;

  assign rd_addr = in_data_i.start_of_frame ? '0 : col_q;

  logic interior, last_px, col_wrap, row_wrap;
  assign interior = (row_q >= RW'(2)) && (col_q >= CW'(2)) &&
                    (32'(row_q) < 32'(h_eff)) && (32'(col_q) < 32'(w_eff));
  assign last_px  = (32'(row_q) == 32'(h_eff) - 32'd1) &&
                    (32'(col_q) == 32'(w_eff) - 32'd1);
  assign col_wrap = (32'(col_q) + 32'd1) >= 32'(w_eff);
  assign row_wrap = (32'(row_q) + 32'd1) >= 32'(h_eff);
  assign status_o.interior = interior;

  // line stores and their registered read data
  logic [PIXEL_BITS-1:0] upper_mem [MAX_WIDTH];
  logic [PIXEL_BITS-1:0] middle_mem [MAX_WIDTH];
  logic [PIXEL_BITS-1:0] prior_mem [MAX_WIDTH];
  logic [PIXEL_BITS-1:0] top_rd_q, mid_rd_q, pri_rd_q;
  logic [PIXEL_BITS-1:0] cur_q, prv_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      top_rd_q <= upper_mem[rd_addr];
      mid_rd_q <= middle_mem[rd_addr];
      pri_rd_q <= prior_mem[rd_addr];
      cur_q    <= in_data_i.curr_pixel;
      prv_q    <= in_data_i.prev_pixel;
    end
    if (cmd_i.upd) begin
      upper_mem[col_q]  <= mid_rd_q;
      middle_mem[col_q] <= cur_q;
      prior_mem[col_q]  <= prv_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      hold_q <= '0;
      for (int i = 0; i < 6; i++) win_q[i] <= '0;
    end else begin
      if (cmd_i.load && in_data_i.start_of_frame) begin
        col_q <= '0;
        row_q <= '0;
      end
      if (cmd_i.upd) begin
        hold_q   <= pri_rd_q;
        win_q[0] <= win_q[1];
        win_q[1] <= top_rd_q;
        win_q[2] <= win_q[3];
        win_q[3] <= mid_rd_q;
        win_q[4] <= win_q[5];
        win_q[5] <= cur_q;
        if (col_wrap) begin
          col_q <= '0;
          row_q <= row_wrap ? '0 : RW'(32'(row_q) + 32'd1);
        end else begin
          col_q <= CW'(32'(col_q) + 32'd1);
        end
      end
    end
  end

  // gradient and difference terms
  logic signed [GRAD_W-1:0] p00, p01, p02, p10, p12, p20, p21, p22;
  logic signed [GRAD_W-1:0] gx, gy;
  logic signed [DIFF_W-1:0] diff;

  always_comb begin
    p00  = $signed({{4{1'b0}}, win_q[0]});
    p01  = $signed({{4{1'b0}}, win_q[1]});
    p10  = $signed({{4{1'b0}}, win_q[2]});
    p20  = $signed({{4{1'b0}}, win_q[4]});
    p21  = $signed({{4{1'b0}}, win_q[5]});
    p02  = $signed({{4{1'b0}}, top_rd_q});
    p12  = $signed({{4{1'b0}}, mid_rd_q});
    p22  = $signed({{4{1'b0}}, cur_q});
    gx   = (p02 + (p12 <<< 1) + p22) - (p00 + (p10 <<< 1) + p20);
    gy   = (p20 + (p21 <<< 1) + p22) - (p00 + (p01 <<< 1) + p02);
    diff = $signed({1'b0, win_q[3]}) - $signed({1'b0, hold_q});
  end

  logic signed [GRAD_W-1:0] gx_q, gy_q;
  logic signed [DIFF_W-1:0] diff_q;
  logic signed [SQ_W-1:0]   gx2_q, gy2_q;
  logic signed [DSQ_W-1:0]  d2s_q;
  logic [SQ_W-1:0]          g2_q;
  logic [DSQ_W-1:0]         d2_q;
  logic [PROD_W-1:0]        e_prod_q, m_prod_q;
  logic [COORD_W-1:0]       crow_q, ccol_q;
  logic                     done_q;
  logic [PROD_W-1:0]        acc;
  fused_req_t               out_q;

  assign acc = e_prod_q + m_prod_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.upd) begin
      gx_q   <= gx;
      gy_q   <= gy;
      diff_q <= diff;
      crow_q <= COORD_W'(32'(row_q) - 32'd1);
      ccol_q <= COORD_W'(32'(col_q) - 32'd1);
      done_q <= last_px;
    end
    if (cmd_i.sq) begin
      gx2_q <= gx_q * gx_q;
      gy2_q <= gy_q * gy_q;
      d2s_q <= diff_q * diff_q;
    end
    if (cmd_i.sum) begin
      g2_q <= $unsigned(gx2_q) + $unsigned(gy2_q);
      d2_q <= $unsigned(d2s_q);
    end
    if (cmd_i.mul) begin
      e_prod_q <= PROD_W'(edge_w_q) * PROD_W'(g2_q);
      m_prod_q <= (PROD_W'(motion_w_q) * PROD_W'(d2_q)) << MOTION_SHL;
    end
    if (cmd_i.out_load) begin
      // drop the fraction, saturate what cannot fit
      if (|acc[PROD_W-1:FRAC_BITS+FUSED_W]) out_q.fused_value <= '1;
      else out_q.fused_value <= acc[FRAC_BITS+FUSED_W-1:FRAC_BITS];
      out_q.center_row <= crow_q;
      out_q.center_col <= ccol_q;
      out_q.frame_done <= done_q;
    end
  end

  assign out_data_o = out_q;

endmodule

// ----- test/tb_sobel_motion_fusion_filter_core.sv -----
// Self-checking testbench for sobel_motion_fusion_filter_core: Sobel gradient
// plus frame-difference fusion over a raster pixel stream, checked per field.
// Depends on smf_pkg and the filter RTL only.
`timescale 1ns / 1ps

module tb_sobel_motion_fusion_filter_core;
  import smf_pkg::*;

  localparam int    SETTLE_CYCLES = 12;
  localparam int    END_CYCLES    = 20;
  localparam int    LIMIT_CYCLES  = 200000;
  localparam longint FUSED_CAP    = (64'd1 << FUSED_W) - 1;

  logic                 clk_i     = 1'b0;
  logic                 rst_ni    = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  pixel_req_t           in_data   = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  fused_req_t           out_data;
  logic                 cfg_we    = 1'b0;
  logic [REG_IDX_W-1:0] cfg_index = REG_FRAME_WIDTH;
  logic [CFG_W-1:0]     cfg_data  = '0;

  sobel_motion_fusion_filter_core DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always #5 clk_i = ~clk_i;

  // Pixel requests waiting to be offered, and fused results still owed.
  pixel_req_t pending_pixels[$];
  fused_req_t expected_fusions[$];

  int unsigned cycle_count  = 0;
  int unsigned pixels_taken = 0;
  int unsigned fusions_seen = 0;
  int unsigned mismatches   = 0;
  bit          drain_hold   = 1'b0;

  // ---------------------------------------------------------------------------
  // Predictor state: its own copy of the registers, line stores and window.
  // ---------------------------------------------------------------------------
  logic [CFG_W-1:0]    width_cfg  = RST_FRAME_WIDTH;
  logic [CFG_W-1:0]    height_cfg = RST_FRAME_HEIGHT;
  logic [WEIGHT_W-1:0] edge_wt    = RST_EDGE_WEIGHT;
  logic [WEIGHT_W-1:0] motion_wt  = RST_MOTION_WEIGHT;

  bit [PIXEL_BITS-1:0] upper_line [DEF_MAX_WIDTH];
  bit [PIXEL_BITS-1:0] middle_line[DEF_MAX_WIDTH];
  bit [PIXEL_BITS-1:0] prior_line [DEF_MAX_WIDTH];
  bit [PIXEL_BITS-1:0] prior_hold;
  // 0/1: top row two and one columns back, 2/3: middle row, 4/5: bottom row
  bit [PIXEL_BITS-1:0] win_px[6];
  int unsigned         col_cnt = 0;
  int unsigned         row_cnt = 0;

  function automatic int unsigned clamp_dim(input logic [CFG_W-1:0] v, input int unsigned hi);
    if (v < 3) return 3;
    if (v > hi) return hi;
    return 32'(v);
  endfunction

  // Advance the predictor by one accepted pixel; queue a result for an
  // interior window center.
  task automatic predict_fusion(input pixel_req_t px);
    int unsigned w, h, col, row, idx;
    int          p00, p01, p10, p11, p20, p21, p02, p12, p22;
    int          gx, gy, d;
    longint      acc;
    bit [PIXEL_BITS-1:0] top, mid, hold_old;
    fused_req_t  res;
    w = clamp_dim(width_cfg, DEF_MAX_WIDTH);
    h = clamp_dim(height_cfg, DEF_MAX_HEIGHT);
    if (px.start_of_frame) begin
      col_cnt = 0;
      row_cnt = 0;
    end
    col = col_cnt;
    row = row_cnt;
    idx = (col < DEF_MAX_WIDTH) ? col : 0;
    top = upper_line[idx];
    mid = middle_line[idx];
    hold_old = prior_hold;

    if (row >= 2 && col >= 2 && row < h && col < w) begin
      p00 = int'(win_px[0]); p01 = int'(win_px[1]);
      p10 = int'(win_px[2]); p11 = int'(win_px[3]);
      p20 = int'(win_px[4]); p21 = int'(win_px[5]);
      p02 = int'(top); p12 = int'(mid); p22 = int'(px.curr_pixel);
      gx  = (p02 + 2 * p12 + p22) - (p00 + 2 * p10 + p20);
      gy  = (p20 + 2 * p21 + p22) - (p00 + 2 * p01 + p02);
      d   = p11 - int'(hold_old);
      acc = longint'(edge_wt) * (longint'(gx) * gx + longint'(gy) * gy)
          + (longint'(motion_wt) << MOTION_SHL) * (longint'(d) * d);
      acc = acc >>> FRAC_BITS;
      if (acc > FUSED_CAP) acc = FUSED_CAP;
      res.fused_value = FUSED_W'(acc);
      res.center_row  = COORD_W'(row - 1);
      res.center_col  = COORD_W'(col - 1);
      res.frame_done  = (row == h - 1) && (col == w - 1);
      expected_fusions.push_back(res);
    end

    // shift the stores and the window
    prior_hold       = prior_line[idx];
    prior_line[idx]  = px.prev_pixel;
    upper_line[idx]  = mid;
    middle_line[idx] = px.curr_pixel;
    win_px[0] = win_px[1]; win_px[1] = top;
    win_px[2] = win_px[3]; win_px[3] = mid;
    win_px[4] = win_px[5]; win_px[5] = px.curr_pixel;

    // wrap on reaching or passing the edge, so shrunk geometry recovers too
    col = col + 1;
    if (col >= w) begin
      col = 0;
      row = row + 1;
      if (row >= h) row = 0;
    end
    col_cnt = col;
    row_cnt = row;
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic logic [PIXEL_BITS-1:0] rand_pixel();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 15) return '0;
    if (pick < 30) return '1;
    return PIXEL_BITS'($urandom_range(0, 255));
  endfunction

  function automatic logic [WEIGHT_W-1:0] rand_weight();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 15) return '0;
    if (pick < 30) return '1;
    return WEIGHT_W'($urandom_range(0, 1023));
  endfunction

  // Queue raster pixels with random content. Track position from the
  // predictor (valid while idle), mostly mark frame starts, sometimes drop
  // the mark and let the counters wrap, and sprinkle in mid-frame restarts.
  task automatic queue_pixels(input int count, input bit sof_first, input int noise_pct);
    int unsigned w, h, gc, gr;
    pixel_req_t  px;
    w  = clamp_dim(width_cfg, DEF_MAX_WIDTH);
    h  = clamp_dim(height_cfg, DEF_MAX_HEIGHT);
    gc = col_cnt;
    gr = row_cnt;
    for (int i = 0; i < count; i++) begin
      px.curr_pixel = rand_pixel();
      px.prev_pixel = rand_pixel();
      if (i == 0)
        px.start_of_frame = sof_first;
      else if (gc == 0 && gr == 0)
        px.start_of_frame = ($urandom_range(0, 99) < 80);
      else
        px.start_of_frame = ($urandom_range(0, 99) < noise_pct);
      if (px.start_of_frame) begin
        gc = 0;
        gr = 0;
      end
      gc++;
      if (gc >= w) begin
        gc = 0;
        gr++;
        if (gr >= h) gr = 0;
      end
      pending_pixels.push_back(px);
    end
  endtask

  // Queue one 3x3 frame in raster order, index 0 first.
  task automatic queue_frame3(input logic [0:8][PIXEL_BITS-1:0] cur,
                              input logic [0:8][PIXEL_BITS-1:0] prv, input bit sof);
    pixel_req_t px;
    for (int k = 0; k < 9; k++) begin
      px.curr_pixel     = cur[k];
      px.prev_pixel     = prv[k];
      px.start_of_frame = sof && (k == 0);
      pending_pixels.push_back(px);
    end
  endtask

  // Drive one register write; the predictor takes the value at once since
  // the block is idle.
  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      REG_FRAME_WIDTH:   width_cfg  = val;
      REG_FRAME_HEIGHT:  height_cfg = val;
      REG_EDGE_WEIGHT:   edge_wt    = val[WEIGHT_W-1:0];
      REG_MOTION_WEIGHT: motion_wt  = val[WEIGHT_W-1:0];
      default: ;
    endcase
  endtask

  task automatic close_writes();
    @(posedge clk_i);
    cfg_we <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic set_geometry(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h,
                              input logic [WEIGHT_W-1:0] ew, input logic [WEIGHT_W-1:0] mw);
    write_reg(REG_FRAME_WIDTH, w);
    write_reg(REG_FRAME_HEIGHT, h);
    write_reg(REG_EDGE_WEIGHT, CFG_W'(ew));
    write_reg(REG_MOTION_WEIGHT, CFG_W'(mw));
    close_writes();
  endtask

  // Wait until every request is taken and every result is back, then give a
  // border pixel still in flight time to finish before touching registers.
  task automatic settle(input int extra);
    do @(negedge clk_i);
    while (pending_pixels.size() != 0 || in_valid || expected_fusions.size() != 0);
    repeat (extra) @(negedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Sender: bursts of random length with random gaps; hold a request until
  // it is taken; pause now and then until all results have drained.
  // ---------------------------------------------------------------------------
  int unsigned burst_left = 0;
  int unsigned gap_left   = 0;

  always @(posedge clk_i or negedge rst_ni) begin : pixel_sender
    logic offer;
    if (!rst_ni) begin
      in_valid <= 1'b0;
      in_data  <= '0;
    end else begin
      if (in_valid && in_ready) begin
        predict_fusion(in_data);
        pixels_taken++;
        if (pixels_taken % 250 == 100) drain_hold = 1'b1;
      end
      if (drain_hold && expected_fusions.size() == 0) drain_hold = 1'b0;

      if (in_valid && !in_ready) begin
        offer = 1'b1;                          // hold the request as it is
      end else if (drain_hold || gap_left > 0 || pending_pixels.size() == 0) begin
        offer = 1'b0;
        if (gap_left > 0 && !drain_hold) gap_left--;
      end else begin
        offer = 1'b1;
        in_data <= pending_pixels.pop_front();
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 24);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
        end
      end
      in_valid <= offer;
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver and checker: compare each result against the oldest expectation;
  // stall in a mode that is re-picked at random intervals, with one long
  // hold-off that backs the block up into its input.
  // ---------------------------------------------------------------------------
  int unsigned rx_mode      = 0;
  int unsigned rx_mode_left = 0;
  int unsigned holdoff_left = 0;

  always @(posedge clk_i or negedge rst_ni) begin : fusion_receiver
    fused_req_t want;
    logic       take;
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_fusions.size() == 0) begin
          $error("result with none expected: fused_value %0d row %0d col %0d",
                 out_data.fused_value, out_data.center_row, out_data.center_col);
          mismatches++;
        end else begin
          want = expected_fusions.pop_front();
          if (out_data.fused_value !== want.fused_value) begin
            $error("fused_value: expected %0d, got %0d", want.fused_value, out_data.fused_value);
            mismatches++;
          end
          if (out_data.center_row !== want.center_row) begin
            $error("center_row: expected %0d, got %0d", want.center_row, out_data.center_row);
            mismatches++;
          end
          if (out_data.center_col !== want.center_col) begin
            $error("center_col: expected %0d, got %0d", want.center_col, out_data.center_col);
            mismatches++;
          end
          if (out_data.frame_done !== want.frame_done) begin
            $error("frame_done: expected %0d, got %0d", want.frame_done, out_data.frame_done);
            mismatches++;
          end
        end
        fusions_seen++;
        if (fusions_seen == 40) holdoff_left = 400;
      end

      if (rx_mode_left == 0) begin
        rx_mode      = $urandom_range(0, 3);
        rx_mode_left = $urandom_range(20, 120);
      end else begin
        rx_mode_left--;
      end

      if (holdoff_left > 0) begin
        holdoff_left--;
        take = 1'b0;
      end else begin
        case (rx_mode)
          0:       take = 1'b1;
          1:       take = ($urandom_range(0, 1) == 1);
          2:       take = ($urandom_range(0, 3) == 0);
          default: take = ($urandom_range(0, 3) != 0);
        endcase
      end
      out_ready <= take;
    end
  end

  // Watchdog: end a hung run.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin : test_sequence
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset geometry: a short stretch of the first 1280-pixel row gives no
    // result.
    queue_pixels(30, 1'b1, 0);
    settle(SETTLE_CYCLES);

    // Small frame at the reset weights: rewrite only the dimensions.
    write_reg(REG_FRAME_WIDTH, 12'd8);
    write_reg(REG_FRAME_HEIGHT, 12'd6);
    close_writes();
    queue_pixels(50, 1'b1, 0);
    settle(SETTLE_CYCLES);

    // Directed 3x3 frames at full weights.
    set_geometry(12'd3, 12'd3, 10'd1023, 10'd1023);
    // strongest horizontal gradient, center brighter in the prior frame
    queue_frame3({8'd0, 8'd0, 8'd255, 8'd0, 8'd0, 8'd255, 8'd0, 8'd0, 8'd255},
                 {9{8'd255}}, 1'b1);
    // no frame start mark: counters wrap on their own; vertical gradient
    queue_frame3({8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0},
                 {9{8'd0}}, 1'b0);
    // two pixels, then a frame start mid-frame with the largest difference
    queue_pixels(2, 1'b1, 0);
    queue_frame3({8'd0, 8'd0, 8'd255, 8'd0, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255},
                 {8'd255, 8'd255, 8'd255, 8'd255, 8'd0, 8'd255, 8'd255, 8'd255, 8'd255},
                 1'b1);
    settle(SETTLE_CYCLES);

    // Dimensions below three clamp up; zero weights give zero results.
    set_geometry(12'd0, 12'd2, 10'd0, 10'd0);
    queue_pixels(40, 1'b1, 0);
    settle(SETTLE_CYCLES);

    // Stop at row 5, column 8 of a 10x6 frame, then shrink both dimensions
    // with no new frame start so column and row pass the new limits.
    set_geometry(12'd10, 12'd6, rand_weight(), rand_weight());
    queue_pixels(58, 1'b1, 0);
    settle(SETTLE_CYCLES);
    set_geometry(12'd5, 12'd4, rand_weight(), rand_weight());
    queue_pixels(60, 1'b0, 0);
    settle(SETTLE_CYCLES);

    // Oversized width and height clamp to the store depth, not below it.
    set_geometry(12'hFFF, 12'd3, rand_weight(), rand_weight());
    queue_pixels(40, 1'b1, 0);
    settle(SETTLE_CYCLES);
    set_geometry(12'd3, 12'hFFF, rand_weight(), rand_weight());
    queue_pixels(60, 1'b1, 0);
    settle(SETTLE_CYCLES);

    // Random small geometries and weights with random frame content.
    for (int ph = 0; ph < 5; ph++) begin
      set_geometry(($urandom_range(0, 5) == 0) ? CFG_W'($urandom_range(0, 2))
                                              : CFG_W'($urandom_range(3, 12)),
                   ($urandom_range(0, 5) == 0) ? CFG_W'($urandom_range(0, 2))
                                              : CFG_W'($urandom_range(3, 8)),
                   rand_weight(), rand_weight());
      queue_pixels(30, 1'b1, 4);
      settle(SETTLE_CYCLES);
    end

    settle(END_CYCLES);
    if (mismatches == 0 && expected_fusions.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
src/smf_pkg.sv
src/smf_ctrl.sv
src/smf_datapath.sv
src/sobel_motion_fusion_filter_core.sv
test/tb_sobel_motion_fusion_filter_core.sv
